[rtl/csfs_pkg.sv]
// Shared constants, payload types and policy codes for the contiguous slot fit search.
package csfs_pkg;

  localparam int SLOTS   = 32;
  localparam int MAP_W   = 32;
  localparam int REQ_W   = 6;
  localparam int START_W = 5;
  localparam int POL_W   = 2;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LEN_W   = $clog2(SLOTS + 1);
  localparam int CMP_W   = (LEN_W > REQ_W) ? LEN_W : REQ_W;

  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  typedef struct packed {
    logic [MAP_W-1:0] occupied_map;
    logic [REQ_W-1:0] requested_size;
  } in_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start_slot;
  } out_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } pick_t;

endpackage

[rtl/csfs_pick.sv]
// Tree selection of the winning free run among all candidate run starts.
module csfs_pick (
  input  logic [csfs_pkg::SLOTS-1:0]                      cand_valid,
  input  logic [csfs_pkg::SLOTS-1:0][csfs_pkg::LEN_W-1:0] cand_len,
  input  logic [csfs_pkg::POL_W-1:0]                      policy,
  output csfs_pkg::pick_t                                 pick
);

  localparam int P     = 1 << csfs_pkg::IDX_W;
  localparam int NODES = 2 * P - 1;
  localparam int KEY_W = csfs_pkg::LEN_W + csfs_pkg::IDX_W;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } node_t;

  node_t                      tree [NODES];
  logic [csfs_pkg::LEN_W-1:0] metric;

  always_comb begin
    for (int i = 0; i < P; i++) begin
      if (i < csfs_pkg::SLOTS) begin
        unique case (policy)
          csfs_pkg::POL_BEST:  metric = cand_len[i];
          csfs_pkg::POL_WORST: metric = ~cand_len[i];
          default:             metric = '0;
        endcase
        tree[P-1+i].valid = cand_valid[i];
      end else begin
        metric            = '0;
        tree[P-1+i].valid = 1'b0;
      end
      // lower index in the key keeps the earliest run on ties
      tree[P-1+i].key = {metric, csfs_pkg::IDX_W'(i)};
    end
    for (int n = P - 2; n >= 0; n--) begin
      if (tree[2*n+1].valid && (!tree[2*n+2].valid || tree[2*n+1].key <= tree[2*n+2].key)) begin
        tree[n] = tree[2*n+1];
      end else begin
        tree[n] = tree[2*n+2];
      end
    end
    pick.found = tree[0].valid;
    pick.index = tree[0].key[csfs_pkg::IDX_W-1:0];
  end

endmodule

[rtl/contiguous_slot_fit_search.sv]
// Top level of the contiguous slot fit search: input register, run search, result register.
// A request is taken into the input stage (in_valid_r, in_data_r); its result is registered in
// the result stage (out_valid_r, out_data_r) and is shown on out_valid and out_data.
// Throughput: one request per cycle; busy stays low, the run search is one registered pass.
// Reset (rst_n low, synchronous): drop all requests in flight and set fit_policy to first fit.
// The receiver cannot stall: each result is presented for exactly one cycle.
module contiguous_slot_fit_search (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  csfs_pkg::in_t                in_data,
  input  logic                         cfg_we,
  input  logic [csfs_pkg::POL_W-1:0]   cfg_wdata,
  output logic                         out_valid,
  output csfs_pkg::out_t               out_data
);

  localparam int S = csfs_pkg::SLOTS;

  logic [csfs_pkg::POL_W-1:0] policy_r;

  // input stage
  logic          in_valid_r;
  csfs_pkg::in_t in_data_r;

  // result stage
  logic           out_valid_r;
  csfs_pkg::out_t out_data_r;
  csfs_pkg::out_t out_data_nxt;

  logic [S-1:0]                      slot_free;
  logic [S-1:0]                      prev_free;
  logic [S-1:0]                      cand_valid;
  logic [S-1:0][csfs_pkg::LEN_W-1:0] cand_len;
  logic [csfs_pkg::LEN_W-1:0]        stop;
  csfs_pkg::pick_t                   pick;

  // every cycle is open for a transfer
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= csfs_pkg::POL_FIRST;
    end else if (cfg_we) begin
      policy_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  // payload registers hold no reset
  always_ff @(posedge clk) begin
    in_data_r  <= in_data;
    out_data_r <= out_data_nxt;
  end

  // Slots past the end of the map read as free; the slot past the last one
  // acts as an occupied boundary that closes the final run.
  always_comb begin
    for (int i = 0; i < S; i++) begin
      if (i < csfs_pkg::MAP_W) begin
        slot_free[i] = !in_data_r.occupied_map[i];
      end else begin
        slot_free[i] = 1'b1;
      end
    end
    prev_free = {slot_free[S-2:0], 1'b0};
  end

  // Each slot that opens a run gets the run's length: the distance to the
  // nearest occupied slot at or above it. A run qualifies when it is at least
  // the requested length; a zero request never qualifies.
  always_comb begin
    for (int i = 0; i < S; i++) begin
      stop = csfs_pkg::LEN_W'(S);
      for (int j = S - 1; j >= 0; j--) begin
        if (j >= i && !slot_free[j]) begin
          stop = csfs_pkg::LEN_W'(j);
        end
      end
      cand_len[i]   = stop - csfs_pkg::LEN_W'(i);
      cand_valid[i] = slot_free[i] && !prev_free[i]
                      && (in_data_r.requested_size != '0)
                      && (csfs_pkg::CMP_W'(cand_len[i])
                          >= csfs_pkg::CMP_W'(in_data_r.requested_size));
    end
  end

  csfs_pick u_pick (
    .cand_valid (cand_valid),
    .cand_len   (cand_len),
    .policy     (policy_r),
    .pick       (pick)
  );

  // force the start slot to zero on failure
  always_comb begin
    out_data_nxt.found      = pick.found;
    out_data_nxt.start_slot = pick.found ? csfs_pkg::START_W'(pick.index) : '0;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // every transfer yields its result strobe through the input and result stages
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 out_valid)
    else $error("result strobe missing two cycles after a transfer");

  // a failed search reports slot zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.start_slot == '0)
    else $error("start slot not zero on failure");

  // a zero-length request never succeeds
  a_zero_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(start, 2) && $past(in_data.requested_size, 2) == '0
    |-> !out_data.found)
    else $error("zero request reported as found");
`endif

endmodule

[test/contiguous_slot_fit_search_tb.sv]
// Self-checking testbench for the contiguous slot fit search: directed and random requests.
module contiguous_slot_fit_search_tb;

  // Edges from a request transfer to its result strobe.
  localparam int FIT_LATENCY    = 2;
  // Cycles without any transfer before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 500;
  // Random requests per policy setting in each idling phase.
  localparam int RANDOM_PER_POLICY = 58;
  // The fourth policy code has no meaning of its own and should act as first fit.
  localparam logic [csfs_pkg::POL_W-1:0] POL_UNUSED = 2'd3;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       start     = 1'b0;
  logic                       busy;
  csfs_pkg::in_t              in_data   = '0;
  logic                       cfg_we    = 1'b0;
  logic [csfs_pkg::POL_W-1:0] cfg_wdata = '0;
  logic                       out_valid;
  csfs_pkg::out_t             out_data;

  // Our own copy of the policy register, updated on the edge that writes it.
  logic [csfs_pkg::POL_W-1:0] model_policy = csfs_pkg::POL_FIRST;
  // Results still owed by the block, oldest first.
  csfs_pkg::out_t             pending_fits[$];

  int sender_idle_pct = 0;
  int requests_sent   = 0;
  int fits_found      = 0;
  int fits_missed     = 0;
  int mismatches      = 0;
  int stall_cycles    = 0;

  contiguous_slot_fit_search u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial forever #5 clk = ~clk;

  // Scan every slot plus one sentinel past the end, so that a run touching the
  // top slot is closed like any other. A run replaces the current pick only
  // when the policy prefers it strictly, which keeps the earliest run on ties.
  function automatic csfs_pkg::out_t predict_slot_fit(csfs_pkg::in_t req,
                                                      logic [csfs_pkg::POL_W-1:0] policy);
    csfs_pkg::out_t res;
    bit             have;
    bit             slot_is_free;
    bit             take;
    int             best_start;
    int             best_len;
    int             run_start;
    int             run_len;
    int             i;
    res        = '0;
    have       = 1'b0;
    best_start = 0;
    best_len   = 0;
    run_start  = 0;
    run_len    = 0;
    // A zero-length request never fits, whatever the map holds.
    if (req.requested_size != 0) begin
      for (i = 0; i <= csfs_pkg::SLOTS; i++) begin
        // Slots past the width of the map carry no bit and count as free.
        slot_is_free = (i < csfs_pkg::SLOTS)
                       && ((i >= csfs_pkg::MAP_W) || !req.occupied_map[i]);
        if (slot_is_free) begin
          if (run_len == 0) run_start = i;
          run_len++;
        end else begin
          if (run_len >= req.requested_size) begin
            if (!have) begin
              take = 1'b1;
            end else if (policy == csfs_pkg::POL_BEST) begin
              take = run_len < best_len;
            end else if (policy == csfs_pkg::POL_WORST) begin
              take = run_len > best_len;
            end else begin
              // First fit, and the unused code with it: keep the first run found.
              take = 1'b0;
            end
            if (take) begin
              have       = 1'b1;
              best_start = run_start;
              best_len   = run_len;
            end
          end
          run_len = 0;
        end
      end
    end
    res.found      = have;
    res.start_slot = have ? best_start[csfs_pkg::START_W-1:0] : '0;
    return res;
  endfunction

  // Vary the density of the map so that long runs, short runs and full maps
  // all turn up; bias the length towards small requests that usually fit.
  function automatic csfs_pkg::in_t random_request();
    csfs_pkg::in_t req;
    case ($urandom_range(6))
      0: req.occupied_map = $urandom;
      1: req.occupied_map = $urandom | $urandom;
      2: req.occupied_map = $urandom & $urandom;
      3: req.occupied_map = $urandom | $urandom | $urandom;
      4: req.occupied_map = $urandom & $urandom & $urandom;
      5: req.occupied_map = ($urandom_range(1) != 0) ? '1 : '0;
      default: req.occupied_map = $urandom << $urandom_range(31);
    endcase
    case ($urandom_range(19))
      0, 1, 2:  req.requested_size = csfs_pkg::REQ_W'($urandom_range(32));
      3, 4, 5:  req.requested_size = csfs_pkg::REQ_W'($urandom_range(63));
      default:  req.requested_size = csfs_pkg::REQ_W'($urandom_range(1, 8));
    endcase
    return req;
  endfunction

  // Present one request, hold it until transferred, record the result it owes,
  // then idle the sender for a random stretch.
  task automatic issue_request(csfs_pkg::in_t item);
    in_data <= item;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    pending_fits.push_back(predict_slot_fit(item, model_policy));
    requests_sent++;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Write the policy only with nothing in flight: drain the owed results, then
  // let the pipeline settle before the write.
  task automatic write_fit_policy(logic [csfs_pkg::POL_W-1:0] code);
    start <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk);
    repeat (FIT_LATENCY) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    model_policy = code;
    cfg_we <= 1'b0;
  endtask

  task automatic report_fault(string why, csfs_pkg::out_t want, csfs_pkg::out_t got);
    if (mismatches < 10) begin
      $display("[%0t] %s: expected found=%0b start_slot=%0d, got found=%0b start_slot=%0d",
               $realtime, why, want.found, want.start_slot, got.found, got.start_slot);
    end
    mismatches++;
  endtask

  // Requests at the edges of the length range, with empty, full and nearly full maps.
  task automatic test_boundary_requests();
    csfs_pkg::in_t req;
    write_fit_policy(csfs_pkg::POL_FIRST);
    req = '{occupied_map: 32'h0000_0000, requested_size: 6'd32}; issue_request(req);
    req = '{occupied_map: 32'h0000_0000, requested_size: 6'd0};  issue_request(req);
    req = '{occupied_map: 32'h0000_0000, requested_size: 6'd33}; issue_request(req);
    req = '{occupied_map: 32'h0000_0000, requested_size: 6'd63}; issue_request(req);
    req = '{occupied_map: 32'hFFFF_FFFF, requested_size: 6'd1};  issue_request(req);
    req = '{occupied_map: 32'hFFFF_FFFE, requested_size: 6'd31}; issue_request(req);
    req = '{occupied_map: 32'h7FFF_FFFF, requested_size: 6'd1};  issue_request(req);
  endtask

  // One map whose runs make first, best and worst fit disagree: free runs of
  // six at slot 1, two at slot 9, three at slot 13 and twelve at slot 20.
  task automatic test_policy_choice();
    logic [csfs_pkg::POL_W-1:0] policies[3];
    csfs_pkg::in_t              req;
    policies = '{csfs_pkg::POL_FIRST, csfs_pkg::POL_BEST, csfs_pkg::POL_WORST};
    foreach (policies[p]) begin
      write_fit_policy(policies[p]);
      req = '{occupied_map: 32'h000F_1981, requested_size: 6'd2}; issue_request(req);
      // Only the top run is long enough, so every policy agrees.
      req = '{occupied_map: 32'h000F_1981, requested_size: 6'd7}; issue_request(req);
      // Two single-slot runs at both ends: a tie that must go to the earlier one.
      req = '{occupied_map: 32'h7FFF_FFFE, requested_size: 6'd1}; issue_request(req);
    end
  endtask

  // The unused policy code should fall back to first fit.
  task automatic test_unused_policy_code();
    csfs_pkg::in_t req;
    write_fit_policy(POL_UNUSED);
    req = '{occupied_map: 32'h000F_1981, requested_size: 6'd2};  issue_request(req);
    req = '{occupied_map: 32'h000F_1981, requested_size: 6'd13}; issue_request(req);
  endtask

  // Random requests under every policy code at the given sender idling rate.
  task automatic test_random_traffic(int idle_pct);
    logic [csfs_pkg::POL_W-1:0] policies[4];
    policies = '{csfs_pkg::POL_FIRST, csfs_pkg::POL_BEST, csfs_pkg::POL_WORST, POL_UNUSED};
    sender_idle_pct = idle_pct;
    foreach (policies[p]) begin
      write_fit_policy(policies[p]);
      repeat (RANDOM_PER_POLICY) issue_request(random_request());
    end
  endtask

  // Check every strobed result against the oldest owed one.
  always @(posedge clk) begin : check_results
    csfs_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (pending_fits.size() == 0) begin
        report_fault("result with no request outstanding", '0, out_data);
      end else begin
        want = pending_fits.pop_front();
        if (out_data.found !== want.found || out_data.start_slot !== want.start_slot) begin
          report_fault("result mismatch", want, out_data);
        end
        if (want.found) fits_found++;
        else fits_missed++;
      end
    end
  end

  // Abandon the run if neither side transfers anything for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    // Hold reset low from the start, then release it for good.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 16;
    test_boundary_requests();
    test_policy_choice();
    test_unused_policy_code();
    test_random_traffic(16);
    test_random_traffic(61);
    test_random_traffic(0);

    // Drain the owed results, then wait on for any stray strobes.
    start <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk);
    repeat (FIT_LATENCY + 2) @(posedge clk);

    $display("Ran %0d requests under first, best, worst fit and the unused policy code",
             requests_sent);
    $display("Results: %0d runs found, %0d failures reported, %0d mismatches",
             fits_found, fits_missed, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
